>>> hdl/swst_pkg.sv
// Shared types and constants of the sliding-window sender tracker.
`timescale 1ns / 1ps

package swst_pkg;

  // Configuration register layout.
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int RELOAD_W   = 8;
  localparam int LIMIT_W    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_RELOAD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT   = 1'd1;

  localparam logic [RELOAD_W-1:0] RELOAD_RESET = 8'd5;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 4'd5;

  // Request and result codes on the ports.
  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] REQ_SEND = 2'd0;
  localparam logic [KIND_W-1:0] REQ_ACK  = 2'd1;
  localparam logic [KIND_W-1:0] REQ_TICK = 2'd2;

  localparam logic [KIND_W-1:0] RES_SEND = 2'd0;
  localparam logic [KIND_W-1:0] RES_ACK  = 2'd1;
  localparam logic [KIND_W-1:0] RES_TICK = 2'd2;

  // Command queue between the front end and the engine.
  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int QPTR_W          = 1;
  localparam int QCNT_W          = 2;

  typedef enum logic [1:0] {
    CMD_SEND,
    CMD_ACK,
    CMD_TICK
  } cmd_e;

  typedef struct packed {
    logic [RELOAD_W-1:0] timeout_reload;
    logic [LIMIT_W-1:0]  window_limit;
  } cfg_t;

endpackage

>>> hdl/swst_front.sv
// Front end: accepts request beats, classifies them and queues commands.
`timescale 1ns / 1ps

module swst_front
  import swst_pkg::*;
#(
  parameter int SEQ_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KIND_W-1:0]   req_type_i,
  input  logic [SEQ_BITS-1:0] ack_seq_i,
  input  logic                final_frame_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output cmd_e                cmd_kind_o,
  output logic [SEQ_BITS-1:0] cmd_seq_o,
  output logic                cmd_final_o
);

  cmd_e                kind;
  logic                known;
  logic                push;
  logic                pop;

  cmd_e                q_kind_q  [CMD_QUEUE_DEPTH];
  logic [SEQ_BITS-1:0] q_seq_q   [CMD_QUEUE_DEPTH];
  logic                q_final_q [CMD_QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;

  // Unknown request codes are taken and dropped without a command.
  always_comb begin
    unique case (req_type_i)
      REQ_SEND: begin kind = CMD_SEND; known = 1'b1; end
      REQ_ACK:  begin kind = CMD_ACK;  known = 1'b1; end
      REQ_TICK: begin kind = CMD_TICK; known = 1'b1; end
      default:  begin kind = CMD_SEND; known = 1'b0; end
    endcase
  end

  assign in_ready_o  = (count_q != QCNT_W'(CMD_QUEUE_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign push        = in_valid_i && in_ready_o && known;
  assign pop         = cmd_valid_o && cmd_ready_i;

  assign cmd_kind_o  = q_kind_q[rd_ptr_q];
  assign cmd_seq_o   = q_seq_q[rd_ptr_q];
  assign cmd_final_o = q_final_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_kind_q[wr_ptr_q]  <= kind;
      q_seq_q[wr_ptr_q]   <= ack_seq_i;
      q_final_q[wr_ptr_q] <= final_frame_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> hdl/swst_engine.sv
// Back end: window state, entry memory, per-entry walk and result register.
`timescale 1ns / 1ps

module swst_engine
  import swst_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8,
  parameter int SEQ_BITS     = 16,
  localparam int SLOT_W      = $clog2(WINDOW_DEPTH),
  localparam int CNT_W       = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  cmd_e                cmd_kind_i,
  input  logic [SEQ_BITS-1:0] cmd_seq_i,
  input  logic                cmd_final_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [KIND_W-1:0]   result_kind_o,
  output logic                accepted_o,
  output logic                resend_valid_o,
  output logic [SEQ_BITS-1:0] frame_seq_o,
  output logic [SLOT_W-1:0]   frame_slot_o,
  output logic                frame_is_final_o,
  output logic [CNT_W-1:0]    window_count_o,
  output logic                last_of_run_o
);

  localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int WORD_W = SEQ_BITS + RELOAD_W + 1;
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
  localparam logic [SLOT_W:0]   DEPTH_SUM = (SLOT_W + 1)'(WINDOW_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEND,
    ST_RD,
    ST_EX,
    ST_RETIRE,
    ST_FLUSH
  } state_e;

  function automatic logic [SLOT_W-1:0] wrap_slot(logic [SLOT_W-1:0] base,
                                                  logic [SLOT_W-1:0] off);
    logic [SLOT_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_SUM) begin
      sum = sum - DEPTH_SUM;
    end
    return sum[SLOT_W-1:0];
  endfunction

  state_e                state_q;
  cmd_e                  kind_q;
  logic [SEQ_BITS-1:0]   ack_seq_q;
  logic                  final_q;
  logic [CNT_W-1:0]      pos_q;
  logic                  hit_q;

  logic [SLOT_W-1:0]     head_q;
  logic [CNT_W-1:0]      occ_q;
  logic [SEQ_BITS-1:0]   next_seq_q;
  logic [WINDOW_DEPTH-1:0] acked_q;

  // Held resend report; it goes out once the next one or the end is known.
  logic                  pend_valid_q;
  logic [SEQ_BITS-1:0]   pend_seq_q;
  logic [SLOT_W-1:0]     pend_slot_q;
  logic                  pend_final_q;

  logic                  out_valid_q;
  logic [KIND_W-1:0]     out_kind_q;
  logic                  out_acc_q;
  logic                  out_rv_q;
  logic [SEQ_BITS-1:0]   out_seq_q;
  logic [SLOT_W-1:0]     out_slot_q;
  logic                  out_fin_q;
  logic [CNT_W-1:0]      out_cnt_q;
  logic                  out_last_q;

  logic [WORD_W-1:0]     entry_mem_q [WINDOW_DEPTH];
  logic [WORD_W-1:0]     rdata_q;

  logic                  out_free;
  logic                  out_load;
  logic [SLOT_W-1:0]     cur_slot;
  logic [SLOT_W-1:0]     tail_slot;
  logic [SLOT_W-1:0]     head_inc;
  logic                  can_send;
  logic [SEQ_BITS-1:0]   rd_seq;
  logic [RELOAD_W-1:0]   rd_timer;
  logic                  rd_final;
  logic                  expired;
  logic                  scan_done;
  logic                  tick_go;
  logic                  mem_we;
  logic [SLOT_W-1:0]     mem_waddr;
  logic [WORD_W-1:0]     mem_wdata;

  assign out_free  = !out_valid_q || out_ready_i;
  assign cur_slot  = wrap_slot(head_q, pos_q[SLOT_W-1:0]);
  assign tail_slot = wrap_slot(head_q, occ_q[SLOT_W-1:0]);
  assign head_inc  = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
  assign can_send  = (CMP_W'(occ_q) < CMP_W'(cfg_i.window_limit)) && (occ_q < DEPTH_CNT);
  assign rd_seq    = rdata_q[SEQ_BITS-1:0];
  assign rd_timer  = rdata_q[SEQ_BITS +: RELOAD_W];
  assign rd_final  = rdata_q[WORD_W-1];
  assign expired   = (rd_timer <= RELOAD_W'(1));
  assign scan_done = (pos_q == occ_q);
  assign tick_go   = !expired || !pend_valid_q || out_free;

  // The output register takes a new beat in this cycle.
  assign out_load  = (state_q == ST_SEND && out_free) ||
                     (state_q == ST_EX && kind_q == CMD_TICK && tick_go && expired &&
                      pend_valid_q) ||
                     (state_q == ST_RETIRE && !(occ_q != '0 && acked_q[head_q]) &&
                      out_free) ||
                     (state_q == ST_FLUSH && out_free);

  assign cmd_ready_o = (state_q == ST_IDLE);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_slot;
    mem_wdata = {rd_final, expired ? cfg_i.timeout_reload : rd_timer - 1'b1, rd_seq};
    if (state_q == ST_SEND && out_free && can_send) begin
      mem_we    = 1'b1;
      mem_waddr = tail_slot;
      mem_wdata = {final_q, cfg_i.timeout_reload, next_seq_q};
    end else if (state_q == ST_EX && kind_q == CMD_TICK && tick_go) begin
      mem_we    = 1'b1;
    end
  end

  // Entry words: {final mark, timer, sequence number}.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= entry_mem_q[cur_slot];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kind_q       <= CMD_SEND;
      ack_seq_q    <= '0;
      final_q      <= 1'b0;
      pos_q        <= '0;
      hit_q        <= 1'b0;
      head_q       <= '0;
      occ_q        <= '0;
      next_seq_q   <= SEQ_BITS'(1);
      acked_q      <= '0;
      pend_valid_q <= 1'b0;
      pend_seq_q   <= '0;
      pend_slot_q  <= '0;
      pend_final_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= RES_SEND;
      out_acc_q    <= 1'b0;
      out_rv_q     <= 1'b0;
      out_seq_q    <= '0;
      out_slot_q   <= '0;
      out_fin_q    <= 1'b0;
      out_cnt_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            kind_q       <= cmd_kind_i;
            ack_seq_q    <= cmd_seq_i;
            final_q      <= cmd_final_i;
            pos_q        <= '0;
            hit_q        <= 1'b0;
            pend_valid_q <= 1'b0;
            state_q      <= (cmd_kind_i == CMD_SEND) ? ST_SEND : ST_RD;
          end
        end
        ST_SEND: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= RES_SEND;
            out_acc_q   <= can_send;
            out_rv_q    <= 1'b0;
            out_seq_q   <= next_seq_q;
            out_slot_q  <= can_send ? tail_slot : '0;
            out_fin_q   <= can_send && final_q;
            out_cnt_q   <= can_send ? occ_q + 1'b1 : occ_q;
            out_last_q  <= 1'b1;
            if (can_send) begin
              acked_q[tail_slot] <= 1'b0;
              occ_q              <= occ_q + 1'b1;
              next_seq_q         <= next_seq_q + 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        ST_RD: begin
          if (scan_done) begin
            state_q <= (kind_q == CMD_ACK) ? ST_RETIRE : ST_FLUSH;
          end else if (kind_q == CMD_TICK && acked_q[cur_slot]) begin
            pos_q <= pos_q + 1'b1;
          end else begin
            state_q <= ST_EX;
          end
        end
        ST_EX: begin
          if (kind_q == CMD_ACK) begin
            if (rd_seq == ack_seq_q) begin
              acked_q[cur_slot] <= 1'b1;
              hit_q             <= 1'b1;
            end
            pos_q   <= pos_q + 1'b1;
            state_q <= ST_RD;
          end else if (tick_go) begin
            if (expired) begin
              if (pend_valid_q) begin
                out_valid_q <= 1'b1;
                out_kind_q  <= RES_TICK;
                out_acc_q   <= 1'b0;
                out_rv_q    <= 1'b1;
                out_seq_q   <= pend_seq_q;
                out_slot_q  <= pend_slot_q;
                out_fin_q   <= pend_final_q;
                out_cnt_q   <= occ_q;
                out_last_q  <= 1'b0;
              end
              pend_valid_q <= 1'b1;
              pend_seq_q   <= rd_seq;
              pend_slot_q  <= cur_slot;
              pend_final_q <= rd_final;
            end
            pos_q   <= pos_q + 1'b1;
            state_q <= ST_RD;
          end
        end
        ST_RETIRE: begin
          if (occ_q != '0 && acked_q[head_q]) begin
            acked_q[head_q] <= 1'b0;
            head_q          <= head_inc;
            occ_q           <= occ_q - 1'b1;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= RES_ACK;
            out_acc_q   <= hit_q;
            out_rv_q    <= 1'b0;
            out_seq_q   <= ack_seq_q;
            out_slot_q  <= '0;
            out_fin_q   <= 1'b0;
            out_cnt_q   <= occ_q;
            out_last_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_kind_q   <= RES_TICK;
            out_acc_q    <= 1'b0;
            out_rv_q     <= pend_valid_q;
            out_seq_q    <= pend_valid_q ? pend_seq_q : '0;
            out_slot_q   <= pend_valid_q ? pend_slot_q : '0;
            out_fin_q    <= pend_valid_q && pend_final_q;
            out_cnt_q    <= occ_q;
            out_last_q   <= 1'b1;
            pend_valid_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = out_kind_q;
  assign accepted_o       = out_acc_q;
  assign resend_valid_o   = out_rv_q;
  assign frame_seq_o      = out_seq_q;
  assign frame_slot_o     = out_slot_q;
  assign frame_is_final_o = out_fin_q;
  assign window_count_o   = out_cnt_q;
  assign last_of_run_o    = out_last_q;

  // The window never holds more entries than it has slots.
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= DEPTH_CNT)
    else $error("window occupancy beyond depth");

  // An accepted send grows the window by exactly one.
  a_send_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEND && out_free && can_send) |=> occ_q == $past(occ_q) + 1'b1)
    else $error("accepted send did not add an entry");

  // Retiring an acknowledged head shrinks the window and moves the head.
  a_retire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RETIRE && occ_q != '0 && acked_q[head_q])
    |=> (occ_q == $past(occ_q) - 1'b1) && (head_q == $past(head_inc)))
    else $error("retire step did not advance the window");

  // A taken command always starts work; the engine leaves idle.
  a_cmd_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && cmd_ready_o) |=> state_q != ST_IDLE)
    else $error("command taken but engine stayed idle");

endmodule

>>> hdl/sliding_window_sender_tracker.sv
// Top level of the sliding-window sender tracker: ports, configuration and wiring.
`timescale 1ns / 1ps

// Sender-side window tracker for a selective-repeat retransmission scheme.
// Each request beat on the input channel is a send (0), an ack (1) or a timer
// tick (2); code 3 is taken and ignored. A send takes the next sequence number
// into the next ring slot if the window is below window_limit and not full,
// and answers with one status beat. An ack marks every live entry carrying
// that number, retires acknowledged entries from the front in order, and
// answers with one status beat. A tick counts down the timers of live,
// unacknowledged entries; each one that expires gives one resend beat and
// has its timer reloaded, and the last beat of the run carries last_of_run.
// A tick with nothing expired gives one quiet beat. Requests pass through a
// two-entry command queue in front of the engine, and results leave from a
// single output register, so the input side keeps accepting while a result
// waits. The engine handles one request at a time: a send checks the window
// and loads its result, while an ack or a tick is taken, then walks the
// window entries one by one through the entry memory, reading each entry and
// then comparing or updating it, sees the end of the walk and loads its
// result; an ack also retires each acknowledged entry in a step of its own,
// and a tick skips acknowledged entries without an update step; a stalled
// output holds the walk. Configuration may be written only while the block
// is idle; it takes effect from the next request.

module sliding_window_sender_tracker
  import swst_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8,
  parameter int SEQ_BITS     = 16,
  localparam int SLOT_W      = $clog2(WINDOW_DEPTH),
  localparam int CNT_W       = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration writes.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Request channel.
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [KIND_W-1:0]     req_type_i,
  input  logic [SEQ_BITS-1:0]   ack_seq_i,
  input  logic                  final_frame_i,
  // Result channel.
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [KIND_W-1:0]     result_kind_o,
  output logic                  accepted_o,
  output logic                  resend_valid_o,
  output logic [SEQ_BITS-1:0]   frame_seq_o,
  output logic [SLOT_W-1:0]     frame_slot_o,
  output logic                  frame_is_final_o,
  output logic [CNT_W-1:0]      window_count_o,
  output logic                  last_of_run_o
);

  cfg_t                cfg_q;
  logic                cmd_valid;
  logic                cmd_ready;
  cmd_e                cmd_kind;
  logic [SEQ_BITS-1:0] cmd_seq;
  logic                cmd_final;

  // Configuration registers. The write data is as wide as the widest
  // register; the window limit takes its low bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_reload <= RELOAD_RESET;
      cfg_q.window_limit   <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TIMEOUT_RELOAD: cfg_q.timeout_reload <= cfg_data_i[RELOAD_W-1:0];
        CFG_WINDOW_LIMIT:   cfg_q.window_limit   <= cfg_data_i[LIMIT_W-1:0];
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  // Front end: accepts request beats and queues known commands.
  swst_front #(
    .SEQ_BITS (SEQ_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .ack_seq_i     (ack_seq_i),
    .final_frame_i (final_frame_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_kind_o    (cmd_kind),
    .cmd_seq_o     (cmd_seq),
    .cmd_final_o   (cmd_final)
  );

  // Engine: window state, entry walk and the output register.
  swst_engine #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SEQ_BITS     (SEQ_BITS)
  ) u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .cmd_valid_i      (cmd_valid),
    .cmd_ready_o      (cmd_ready),
    .cmd_kind_i       (cmd_kind),
    .cmd_seq_i        (cmd_seq),
    .cmd_final_i      (cmd_final),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_o    (result_kind_o),
    .accepted_o       (accepted_o),
    .resend_valid_o   (resend_valid_o),
    .frame_seq_o      (frame_seq_o),
    .frame_slot_o     (frame_slot_o),
    .frame_is_final_o (frame_is_final_o),
    .window_count_o   (window_count_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule
